>>> rtl/core/fmp_pkg.sv
// fmp_pkg: shared constants, register indexes and types of the pooling block
// used by the other files under rtl/core except fmp_divider; depends on nothing

package fmp_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_HEIGHT   = 256;
  localparam int DEF_MAX_POOL     = 8;
  localparam int DEF_MAX_CHANNELS = 1024;
  localparam int DEF_DATA_WIDTH   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 3'd5;

  // stride is held to one through eight, phases fit three bits
  localparam int STRIDE_MAX = 8;
  localparam int PHASE_W    = 3;

  // result field widths
  localparam int CH_OUT_W  = 10;
  localparam int POS_OUT_W = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_CALC,
    ST_WAIT,
    ST_OUT
  } fmp_state_t;

  // controls one accumulation step of the window reducer
  typedef struct packed {
    logic en;
    logic first;
  } fmp_red_ctl_t;

endpackage

>>> rtl/core/feature_map_pooling.sv
// feature_map_pooling: streaming 2d max / average pooling of a q8.8 feature map
// depends on fmp_pkg, fmp_row_store, fmp_reduce and fmp_divider
//
// items enter on the in_ stream one activation at a time, channel-major then
// row-major. a result item leaves on the out_ stream for each pixel that is
// the bottom-right corner of a window on the stride grid; tlast marks the
// last window of the last channel. registers are written on the cfg_ port.
// an item that completes no window is taken with in_tready staying high. an item
// that completes a window holds in_tready low while the window is reduced: the
// window rows are read from the banked row store, one row per cycle (pool_size
// rows), the drain and calc states finish the fold, then the wait for the serial
// dividers (output row and column and last grid row and column, one bit a cycle
// over the counter width, and in average mode the sum divider, one bit a cycle
// over the sum width, 22 at default sizes), then the output register is loaded
// once any earlier result has been taken.
// the output register lets the next item enter while a result waits; a stalled
// receiver only blocks the block when a second window result is ready.
// reset clears counters and config registers to defaults; the row store needs no
// clearing, every entry is written before a window reads it.

module feature_map_pooling #(
  parameter int MAX_WIDTH    = fmp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = fmp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_POOL     = fmp_pkg::DEF_MAX_POOL,
  parameter int MAX_CHANNELS = fmp_pkg::DEF_MAX_CHANNELS,
  parameter int DATA_WIDTH   = fmp_pkg::DEF_DATA_WIDTH,
  localparam int IN_TW  = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((DATA_WIDTH + fmp_pkg::CH_OUT_W + 2 * fmp_pkg::POS_OUT_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fmp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_TW-1:0]                  in_tdata,   // sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_TW-1:0]                 out_tdata,  // value, out_channel, out_row, out_col
  output logic                              out_tlast
);
  import fmp_pkg::*;

  localparam int NB    = MAX_POOL;
  localparam int BW    = (NB > 1) ? $clog2(NB) : 1;
  localparam int NWORD = (MAX_WIDTH + NB - 1) / NB;
  localparam int WW    = (NWORD > 1) ? $clog2(NWORD) : 1;
  localparam int PW    = $clog2(MAX_POOL + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CWD   = $clog2(MAX_WIDTH + 1);
  localparam int CW    = $clog2(MAX_CHANNELS + 1);
  localparam int AW    = DATA_WIDTH + $clog2(MAX_POOL * MAX_POOL);
  localparam int PSQW  = $clog2(MAX_POOL * MAX_POOL + 1);
  localparam int DW    = DATA_WIDTH;
  localparam int PAD_W = OUT_TW - DW - CH_OUT_W - 2 * POS_OUT_W;

  // configuration registers
  logic        mode_r;
  logic [3:0]  pool_r;
  logic [3:0]  stride_r;
  logic [8:0]  height_r;
  logic [8:0]  width_r;
  logic [10:0] chans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      pool_r   <= 4'd2;
      stride_r <= 4'd2;
      height_r <= 9'd1;
      width_r  <= 9'd1;
      chans_r  <= 11'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:      mode_r   <= cfg_data[0];
        CFG_POOL_SIZE: pool_r   <= cfg_data[3:0];
        CFG_STRIDE:    stride_r <= cfg_data[3:0];
        CFG_HEIGHT:    height_r <= cfg_data[8:0];
        CFG_WIDTH:     width_r  <= cfg_data[8:0];
        CFG_CHANNELS:  chans_r  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions
  logic [PW-1:0]  p_c;
  logic [3:0]     s_c;
  logic [HW-1:0]  h_c;
  logic [CWD-1:0] w_c;
  logic [CW-1:0]  n_c;

  always_comb begin
    p_c = (pool_r == 4'd0) ? PW'(1) :
          (int'(pool_r) > MAX_POOL) ? PW'(MAX_POOL) : PW'(pool_r);
    s_c = (stride_r == 4'd0) ? 4'd1 :
          (int'(stride_r) > STRIDE_MAX) ? 4'(STRIDE_MAX) : stride_r;
    h_c = (height_r == 9'd0) ? HW'(1) :
          (int'(height_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_r);
    w_c = (width_r == 9'd0) ? CWD'(1) :
          (int'(width_r) > MAX_WIDTH) ? CWD'(MAX_WIDTH) : CWD'(width_r);
    n_c = (chans_r == 11'd0) ? CW'(1) :
          (int'(chans_r) > MAX_CHANNELS) ? CW'(MAX_CHANNELS) : CW'(chans_r);
  end

  // position counters; rslot = row mod banks, cbank / cword = column mod / div banks
  logic [HW-1:0]      r_r;
  logic [CWD-1:0]     c_r;
  logic [CW-1:0]      ch_r;
  logic [PHASE_W-1:0] rph_r;
  logic [PHASE_W-1:0] cph_r;
  logic [BW-1:0]      rslot_r;
  logic [BW-1:0]      cbank_r;
  logic [WW-1:0]      cword_r;

  logic [HW-1:0]      r_eff;
  logic [CWD-1:0]     c_eff;
  logic [CW-1:0]      ch_eff;
  logic [BW-1:0]      rslot_eff;
  logic [BW-1:0]      cbank_eff;
  logic [WW-1:0]      cword_eff;
  logic               row_hit;
  logic               col_hit;
  logic               hit_w;

  logic [HW-1:0]      r_nxt;
  logic [CWD-1:0]     c_nxt;
  logic [CW-1:0]      ch_nxt;
  logic [PHASE_W-1:0] rph_nxt;
  logic [PHASE_W-1:0] cph_nxt;
  logic [BW-1:0]      rslot_nxt;
  logic [BW-1:0]      cbank_nxt;
  logic [WW-1:0]      cword_nxt;

  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    logic          r_wrap;
    logic          c_wrap;
    logic [HW-1:0] r_inc;
    logic [CWD-1:0] c_inc;
    logic [CW-1:0] ch_inc;

    // counters left past a shrunken dimension restart at zero
    r_wrap    = (r_r >= h_c);
    c_wrap    = (c_r >= w_c);
    r_eff     = r_wrap ? '0 : r_r;
    rslot_eff = r_wrap ? '0 : rslot_r;
    c_eff     = c_wrap ? '0 : c_r;
    cbank_eff = c_wrap ? '0 : cbank_r;
    cword_eff = c_wrap ? '0 : cword_r;
    ch_eff    = (ch_r >= n_c) ? '0 : ch_r;

    row_hit = (int'(h_c) >= int'(p_c)) && (int'(r_eff) >= int'(p_c) - 1) &&
              (rph_r == '0);
    col_hit = (int'(w_c) >= int'(p_c)) && (int'(c_eff) >= int'(p_c) - 1) &&
              (cph_r == '0);
    hit_w   = row_hit && col_hit;

    rph_nxt = rph_r;
    cph_nxt = cph_r;
    if (int'(c_eff) >= int'(p_c) - 1) begin
      cph_nxt = (int'(cph_r) + 1 >= int'(s_c)) ? '0 : cph_r + PHASE_W'(1);
    end
    c_inc  = c_eff + CWD'(1);
    r_inc  = r_eff + HW'(1);
    ch_inc = ch_eff + CW'(1);
    if (int'(cbank_eff) == NB - 1) begin
      cbank_nxt = '0;
      cword_nxt = cword_eff + WW'(1);
    end else begin
      cbank_nxt = cbank_eff + BW'(1);
      cword_nxt = cword_eff;
    end
    c_nxt     = c_inc;
    r_nxt     = r_eff;
    rslot_nxt = rslot_eff;
    ch_nxt    = ch_eff;
    if (c_inc >= w_c) begin
      c_nxt     = '0;
      cbank_nxt = '0;
      cword_nxt = '0;
      cph_nxt   = '0;
      if (int'(r_eff) >= int'(p_c) - 1) begin
        rph_nxt = (int'(rph_r) + 1 >= int'(s_c)) ? '0 : rph_r + PHASE_W'(1);
      end
      r_nxt     = r_inc;
      rslot_nxt = (int'(rslot_eff) == NB - 1) ? '0 : rslot_eff + BW'(1);
      if (r_inc >= h_c) begin
        r_nxt     = '0;
        rslot_nxt = '0;
        rph_nxt   = '0;
        ch_nxt    = (ch_inc >= n_c) ? '0 : ch_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r     <= '0;
      c_r     <= '0;
      ch_r    <= '0;
      rph_r   <= '0;
      cph_r   <= '0;
      rslot_r <= '0;
      cbank_r <= '0;
      cword_r <= '0;
    end else if (in_acc) begin
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      ch_r    <= ch_nxt;
      rph_r   <= rph_nxt;
      cph_r   <= cph_nxt;
      rslot_r <= rslot_nxt;
      cbank_r <= cbank_nxt;
      cword_r <= cword_nxt;
    end
  end

  // window job
  fmp_state_t state_r, state_nxt;

  logic [HW-1:0]  job_r_r;
  logic [CWD-1:0] job_c_r;
  logic [CW-1:0]  job_ch_r;
  logic [BW-1:0]  job_cbank_r;
  logic [WW-1:0]  job_cword_r;
  logic [BW-1:0]  rd_slot_r;
  logic [PW-1:0]  rd_cnt_r;
  logic           first_r;
  logic           job_start;
  logic           rd_en;
  logic           avg_start;
  logic           div_busy;
  logic           out_load;
  logic           neg_r;

  assign job_start = in_acc && hit_w;
  assign rd_en     = (state_r == ST_READ);
  assign avg_start = (state_r == ST_CALC) && mode_r;
  assign out_load  = (state_r == ST_OUT) && (!out_tvalid || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (job_start) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt_r == p_c - PW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (!div_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_start) begin
      job_r_r     <= r_eff;
      job_c_r     <= c_eff;
      job_ch_r    <= ch_eff;
      job_cbank_r <= cbank_eff;
      job_cword_r <= cword_eff;
    end
  end

  // read pointer walks the window rows from the oldest slot
  always_ff @(posedge clk) begin
    if (job_start) begin
      int t;
      t = int'(rslot_eff) + NB - int'(p_c) + 1;
      if (t >= NB) begin
        t = t - NB;
      end
      rd_slot_r <= BW'(t);
      rd_cnt_r  <= '0;
    end else if (rd_en) begin
      rd_slot_r <= (int'(rd_slot_r) == NB - 1) ? '0 : rd_slot_r + BW'(1);
      rd_cnt_r  <= rd_cnt_r + PW'(1);
    end
  end

  logic [NB-1:0][DW-1:0] st_data;
  logic [NB-1:0]         st_mask;
  logic                  st_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0;
    end else if (job_start) begin
      first_r <= 1'b1;
    end else if (st_valid) begin
      first_r <= 1'b0;
    end
  end

  fmp_row_store #(
    .NB(NB), .NWORD(NWORD), .DW(DW), .BW(BW), .WW(WW), .PW(PW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc),
    .wr_slot  (rslot_eff),
    .wr_bank  (cbank_eff),
    .wr_word  (cword_eff),
    .wr_data  (in_tdata[DW-1:0]),
    .rd_en    (rd_en),
    .rd_slot  (rd_slot_r),
    .rd_bank  (job_cbank_r),
    .rd_word  (job_cword_r),
    .rd_p     (p_c),
    .rd_data  (st_data),
    .rd_mask  (st_mask),
    .rd_valid (st_valid)
  );

  fmp_red_ctl_t         red_ctl;
  logic signed [AW-1:0] acc;
  logic signed [DW-1:0] best;

  assign red_ctl.en    = st_valid;
  assign red_ctl.first = first_r;

  fmp_reduce #(.NB(NB), .DW(DW), .AW(AW)) u_reduce (
    .clk       (clk),
    .ctl       (red_ctl),
    .lane_data (st_data),
    .lane_mask (st_mask),
    .acc       (acc),
    .best      (best)
  );

  // dividers: output row, output column, last grid row / column, window mean
  logic [HW-1:0]  q_row;
  logic [CWD-1:0] q_col;
  logic [HW-1:0]  q_h;
  logic [CWD-1:0] q_w;
  logic [AW-1:0]  q_avg;
  logic [AW-1:0]  acc_mag;
  logic           b_row, b_col, b_h, b_w, b_avg;

  assign acc_mag  = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign div_busy = b_row || b_col || b_h || b_w || b_avg;

  always_ff @(posedge clk) begin
    if (avg_start) begin
      neg_r <= acc[AW-1];
    end
  end

  fmp_divider #(.NW(HW), .DVW(4)) u_div_row (
    .clk (clk), .rst_n (rst_n), .start (job_start),
    .dividend (HW'(int'(r_eff) - int'(p_c) + 1)), .divisor (s_c),
    .busy (b_row), .quotient (q_row)
  );

  fmp_divider #(.NW(CWD), .DVW(4)) u_div_col (
    .clk (clk), .rst_n (rst_n), .start (job_start),
    .dividend (CWD'(int'(c_eff) - int'(p_c) + 1)), .divisor (s_c),
    .busy (b_col), .quotient (q_col)
  );

  fmp_divider #(.NW(HW), .DVW(4)) u_div_h (
    .clk (clk), .rst_n (rst_n), .start (job_start),
    .dividend (HW'(int'(h_c) - int'(p_c))), .divisor (s_c),
    .busy (b_h), .quotient (q_h)
  );

  fmp_divider #(.NW(CWD), .DVW(4)) u_div_w (
    .clk (clk), .rst_n (rst_n), .start (job_start),
    .dividend (CWD'(int'(w_c) - int'(p_c))), .divisor (s_c),
    .busy (b_w), .quotient (q_w)
  );

  fmp_divider #(.NW(AW), .DVW(PSQW)) u_div_avg (
    .clk (clk), .rst_n (rst_n), .start (avg_start),
    .dividend (acc_mag), .divisor (PSQW'(p_c) * PSQW'(p_c)),
    .busy (b_avg), .quotient (q_avg)
  );

  // result assembly
  logic [DW-1:0] avg_val;
  logic          last_w;
  logic          out_valid_r;
  logic [DW-1:0] out_value_r;
  logic [CH_OUT_W-1:0]  out_ch_r;
  logic [POS_OUT_W-1:0] out_row_r;
  logic [POS_OUT_W-1:0] out_col_r;
  logic          out_last_r;

  assign avg_val = neg_r ? DW'(-q_avg[DW-1:0]) : q_avg[DW-1:0];
  assign last_w  = (int'(job_r_r) == int'(p_c) - 1 + int'(q_h) * int'(s_c)) &&
                   (int'(job_c_r) == int'(p_c) - 1 + int'(q_w) * int'(s_c)) &&
                   (int'(job_ch_r) == int'(n_c) - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= mode_r ? avg_val : best;
      out_ch_r    <= CH_OUT_W'(job_ch_r);
      out_row_r   <= POS_OUT_W'(q_row);
      out_col_r   <= POS_OUT_W'(q_col);
      out_last_r  <= last_w;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_col_r, out_row_r, out_ch_r, out_value_r};

`ifndef SYNTHESIS
  a_busy_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    job_start |=> !in_tready)
    else $error("item accepted during window reduction");

  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (rd_cnt_r < p_c))
    else $error("window row read past pool size");

  a_avg_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) && !mode_r |-> !b_avg)
    else $error("average divider running in maximum mode");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_tdata))
    else $error("pending result overwritten");
`endif

endmodule

>>> rtl/core/fmp_row_store.sv
// fmp_row_store: banked row store, one bank per column modulo the bank count
// reads one whole window row per cycle while rd_en is high; uses fmp_pkg

module fmp_row_store #(
  parameter int NB    = fmp_pkg::DEF_MAX_POOL,
  parameter int NWORD = 32,
  parameter int DW    = fmp_pkg::DEF_DATA_WIDTH,
  parameter int BW    = 3,
  parameter int WW    = 5,
  parameter int PW    = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [BW-1:0]          wr_slot,
  input  logic [BW-1:0]          wr_bank,
  input  logic [WW-1:0]          wr_word,
  input  logic [DW-1:0]          wr_data,
  input  logic                   rd_en,
  input  logic [BW-1:0]          rd_slot,
  input  logic [BW-1:0]          rd_bank,
  input  logic [WW-1:0]          rd_word,
  input  logic [PW-1:0]          rd_p,
  output logic [NB-1:0][DW-1:0]  rd_data,
  output logic [NB-1:0]          rd_mask,
  output logic                   rd_valid
);
  import fmp_pkg::*;

  logic [NB-1:0]         mask_w;
  logic [NB-1:0][WW-1:0] word_w;
  logic [NB-1:0][DW-1:0] rdata_r;
  logic [NB-1:0]         mask_r;
  logic                  valid_r;

  // bank b holds column c - k of the window row, k counted back from the corner bank
  always_comb begin
    int k;
    for (int b = 0; b < NB; b++) begin
      if (b <= int'(rd_bank)) begin
        k         = int'(rd_bank) - b;
        word_w[b] = rd_word;
      end else begin
        k         = int'(rd_bank) + NB - b;
        word_w[b] = rd_word - WW'(1);
      end
      mask_w[b] = (k < int'(rd_p));
    end
  end

  for (genvar g = 0; g < NB; g++) begin : g_bank
    logic [DW-1:0] bank_mem [NB][NWORD];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == BW'(g))) begin
        bank_mem[wr_slot][wr_word] <= wr_data;
      end
      if (rd_en) begin
        rdata_r[g] <= bank_mem[rd_slot][word_w[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mask_r <= mask_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= rd_en;
    end
  end

  assign rd_data  = rdata_r;
  assign rd_mask  = mask_r;
  assign rd_valid = valid_r;

endmodule

>>> rtl/core/fmp_reduce.sv
// fmp_reduce: folds one window row per step into a running sum and maximum
// uses fmp_pkg for the step control struct

module fmp_reduce #(
  parameter int NB = fmp_pkg::DEF_MAX_POOL,
  parameter int DW = fmp_pkg::DEF_DATA_WIDTH,
  parameter int AW = 22
) (
  input  logic                  clk,
  input  fmp_pkg::fmp_red_ctl_t ctl,
  input  logic [NB-1:0][DW-1:0] lane_data,
  input  logic [NB-1:0]         lane_mask,
  output logic signed [AW-1:0]  acc,
  output logic signed [DW-1:0]  best
);
  import fmp_pkg::*;

  logic signed [AW-1:0] row_sum;
  logic signed [DW-1:0] row_max;
  logic signed [AW-1:0] acc_r;
  logic signed [DW-1:0] best_r;

  always_comb begin
    logic found;
    found   = 1'b0;
    row_sum = '0;
    row_max = '0;
    for (int b = 0; b < NB; b++) begin
      if (lane_mask[b]) begin
        row_sum = row_sum + AW'($signed(lane_data[b]));
        if (!found || ($signed(lane_data[b]) > row_max)) begin
          row_max = $signed(lane_data[b]);
        end
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.first) begin
        acc_r  <= row_sum;
        best_r <= row_max;
      end else begin
        acc_r  <= acc_r + row_sum;
        best_r <= (row_max > best_r) ? row_max : best_r;
      end
    end
  end

  assign acc  = acc_r;
  assign best = best_r;

endmodule

>>> rtl/core/fmp_divider.sv
// fmp_divider: unsigned restoring divider, one quotient bit per cycle
// standalone, no package needed

module fmp_divider #(
  parameter int NW  = 8,
  parameter int DVW = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           busy,
  output logic [NW-1:0]  quotient
);
  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   quo_r;
  logic [DVW-1:0]  rem_r;
  logic [DVW-1:0]  dvs_r;
  logic [DVW:0]    shifted;
  logic            ge;
  logic [DVW-1:0]  rem_nxt;

  assign shifted = {rem_r, quo_r[NW-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});
  assign rem_nxt = ge ? DVW'(shifted - {1'b0, dvs_r}) : DVW'(shifted);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= NW'({quo_r, ge});
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> tb/fmp_checker.sv
// fmp_checker: watches the in_ and out_ streams of feature_map_pooling, predicts
// each pooled window and compares it with the result stream; depends on fmp_pkg
`timescale 1ns / 1ps

module fmp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_windows,
  output int          window_count
);
  import fmp_pkg::*;

  typedef struct packed {
    logic signed [15:0] value;
    logic [9:0]         chan;
    logic [7:0]         orow;
    logic [7:0]         ocol;
    logic               last;
  } window_t;

  window_t window_q[$];

  logic        pool_avg;
  logic [3:0]  r_pool, r_stride;
  logic [8:0]  r_height, r_width;
  logic [10:0] r_chans;

  logic signed [15:0] plane[8][256];
  int unsigned row_idx, col_idx, chan_idx, row_ph, col_ph;

  assign pending_windows = window_q.size();

  function automatic int unsigned clampv(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic pool_sample(input logic signed [15:0] smp);
    int unsigned p, s, h, w, ch, r, c, rr, cc, lr, lc;
    longint acc;
    logic signed [15:0] best, v;
    window_t win;
    p = clampv(r_pool, 8);
    s = clampv(r_stride, 8);
    h = clampv(r_height, 256);
    w = clampv(r_width, 256);
    ch = clampv(r_chans, 1024);
    r = row_idx;
    c = col_idx;
    if (r >= h) r = 0;
    if (c >= w) c = 0;
    if (chan_idx >= ch) chan_idx = 0;
    plane[r % 8][c] = smp;
    if (h >= p && r >= p - 1 && row_ph == 0 && w >= p && c >= p - 1 && col_ph == 0) begin
      acc = 0;
      best = plane[(r - (p - 1)) % 8][c - (p - 1)];
      for (int i = 0; i < p; i++) begin
        rr = r - (p - 1) + i;
        for (int j = 0; j < p; j++) begin
          cc = c - (p - 1) + j;
          v = plane[rr % 8][cc];
          acc += v;
          if (v > best) best = v;
        end
      end
      lr = (p - 1) + ((h - p) / s) * s;
      lc = (p - 1) + ((w - p) / s) * s;
      win.value = pool_avg ? 16'(acc / longint'(p * p)) : best;
      win.chan = chan_idx[9:0];
      win.orow = 8'((r - (p - 1)) / s);
      win.ocol = 8'((c - (p - 1)) / s);
      win.last = (r == lr && c == lc && chan_idx == ch - 1);
      window_q.push_back(win);
    end
    if (c >= p - 1) col_ph = (col_ph + 1 >= s) ? 0 : col_ph + 1;
    c++;
    if (c >= w) begin
      c = 0;
      col_ph = 0;
      if (r >= p - 1) row_ph = (row_ph + 1 >= s) ? 0 : row_ph + 1;
      r++;
      if (r >= h) begin
        r = 0;
        row_ph = 0;
        chan_idx++;
        if (chan_idx >= ch) chan_idx = 0;
      end
    end
    row_idx = r;
    col_idx = c;
  endtask

  always @(posedge clk) begin
    window_t got, want;
    if (!rst_n) begin
      pool_avg <= 1'b0;
      r_pool <= 4'd2;
      r_stride <= 4'd2;
      r_height <= 9'd1;
      r_width <= 9'd1;
      r_chans <= 11'd1;
      row_idx = 0; col_idx = 0; chan_idx = 0; row_ph = 0; col_ph = 0;
      window_q.delete();
      fail_count <= 0;
      window_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:      pool_avg <= cfg_data[0];
          CFG_POOL_SIZE: r_pool <= cfg_data[3:0];
          CFG_STRIDE:    r_stride <= cfg_data[3:0];
          CFG_HEIGHT:    r_height <= cfg_data[8:0];
          CFG_WIDTH:     r_width <= cfg_data[8:0];
          CFG_CHANNELS:  r_chans <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) pool_sample(in_tdata);
      if (out_tvalid && out_tready) begin
        window_count <= window_count + 1;
        got = {out_tdata[15:0], out_tdata[25:16], out_tdata[33:26], out_tdata[41:34],
               out_tlast};
        if (window_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected window result %h", got);
        end else begin
          want = window_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("window mismatch: exp val %0d ch %0d r %0d c %0d l %b, got val %0d ch %0d r %0d c %0d l %b",
                       want.value, want.chan, want.orow, want.ocol, want.last,
                       got.value, got.chan, got.orow, got.ocol, got.last);
          end
        end
      end
    end
  end
endmodule

>>> tb/tb_feature_map_pooling.sv
// tb_feature_map_pooling: drives pooling maps under several register settings
// with random gaps and stalls; depends on fmp_pkg, fmp_checker and the block
`timescale 1ns / 1ps

module tb_feature_map_pooling;
  import fmp_pkg::*;

  localparam int WATCHDOG = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic out_tlast;
  int fail_count, pending_windows, window_count;
  int idle_cycles = 0;
  int hold_off = 0;
  bit drive_done = 0;
  int samples_sent = 0;

  always #5 clk = ~clk;

  feature_map_pooling dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  fmp_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .fail_count(fail_count),
    .pending_windows(pending_windows), .window_count(window_count)
  );

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (drive_done) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no progress, %0d windows pending", pending_windows);
      $display("[feature_map_pooling] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 11'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (pending_windows != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] smp, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic run_map(input int avg, input int p, input int s, input int h,
                         input int w, input int ch, input int kind);
    logic [15:0] smp;
    settle();
    write_reg(CFG_MODE, avg);
    write_reg(CFG_POOL_SIZE, p);
    write_reg(CFG_STRIDE, s);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_CHANNELS, ch);
    for (int n = 0; n < h * w * ch; n++) begin
      case (kind)
        0: smp = 16'h7fff;
        1: smp = 16'h8000;
        2: smp = n[0] ? 16'h8000 : 16'h7fff;
        default: smp = 16'($urandom());
      endcase
      send_sample(smp, kind >= 3);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    int p, s, h, w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, both kinds, map smaller than window, one-wide window
    run_map(0, 2, 2, 2, 2, 1, 0);
    run_map(1, 2, 2, 2, 2, 1, 1);
    run_map(1, 2, 1, 2, 3, 1, 2);
    run_map(0, 3, 1, 2, 2, 1, 3);
    run_map(0, 1, 1, 3, 2, 1, 3);
    run_map(1, 8, 8, 8, 1, 1, 3);
    // long receiver hold-off while items keep coming
    settle();
    hold_off = 300;
    run_map(0, 1, 1, 4, 4, 2, 3);
    // random maps, mostly small sizes
    while (samples_sent < 500) begin
      p = $urandom_range(1, 4);
      s = $urandom_range(1, 8);
      h = $urandom_range(1, 9);
      w = $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0) begin
        p = $urandom_range(5, 8);
        h = $urandom_range(p, 10);
        w = $urandom_range(p, 12);
      end
      run_map($urandom_range(0, 1), p, s, h, w, $urandom_range(1, 3), 3);
    end
    // widest row and largest channel count edges
    run_map(1, 2, 1, 2, 256, 1, 3);
    run_map(0, 1, 8, 1, 1, 1024, 3);
    drive_done = 1;
    settle();
    $display("covered %0d samples and %0d pooled windows over max and average maps",
             samples_sent, window_count);
    if (fail_count == 0) begin
      $display("[feature_map_pooling] OK");
    end else begin
      $display("[feature_map_pooling] ERROR");
    end
    $finish;
  end
endmodule

>>> feature_map_pooling.f
rtl/core/fmp_pkg.sv
rtl/core/fmp_row_store.sv
rtl/core/fmp_reduce.sv
rtl/core/fmp_divider.sv
rtl/core/feature_map_pooling.sv
tb/fmp_checker.sv
tb/tb_feature_map_pooling.sv
